>>> rtl/tlca_pkg.sv
// Shared constants, codes and control types of the tree LCA block.
package tlca_pkg;

  localparam int NODE_W          = 10;
  localparam int MAX_NODES_DEF   = 1024;
  localparam int LIFT_LEVELS_DEF = 10;

  typedef enum logic [0:0] {
    OP_ATTACH = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ATT_START,
    ST_ATT_LVL,
    ST_Q_START,
    ST_Q_DEPTH_U,
    ST_Q_DEPTH_V,
    ST_Q_LIFT,
    ST_Q_PAIR,
    ST_Q_FINAL,
    ST_RESULT
  } state_t;

  typedef enum logic [3:0] {
    DP_HOLD,
    DP_LOAD,
    DP_ATT_START,
    DP_ATT_LVL,
    DP_Q_START,
    DP_Q_DEPTH_U,
    DP_Q_DEPTH_V,
    DP_Q_LIFT,
    DP_Q_PAIR
  } dp_op_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_U,
    RES_LIFT,
    RES_ANC
  } res_sel_t;

  typedef struct packed {
    dp_op_t   op;
    logic     depth_we;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic attach_ok;
    logic range_ok;
    logic same;
    logic lift_meet;
  } dp_stat_t;

endpackage

>>> rtl/tree_lca_binary_lifting.sv
// Top level of the tree lowest-common-ancestor block (binary lifting).
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_stall    in_op, in_node_a, in_node_b
//  out_     output     out_valid / out_stall  out_ancestor_node
//
// An attach item writes the parent as its level-0 entry and then fills the
// higher ancestor levels in order, each level a read of the previous
// level's entry.
// A query does two depth reads, one pass over the levels lifting the deeper
// node, one pass lifting both nodes with the paired table copies, and a
// final parent read; it ends early when the nodes match or are out of range.
// One item is worked on at a time.
// Reset clears the sequencer and the result slot; no memory clearing pass.
// A stalled result waits in the output register while the next item is taken;
// a later query waits for that register before it finishes.
module tree_lca_binary_lifting #(
  parameter int MAX_NODES   = tlca_pkg::MAX_NODES_DEF,
  parameter int LIFT_LEVELS = tlca_pkg::LIFT_LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [tlca_pkg::NODE_W-1:0] in_node_a,
  input  logic [tlca_pkg::NODE_W-1:0] in_node_b,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tlca_pkg::NODE_W-1:0] out_ancestor_node
);

  localparam int LW = $clog2(LIFT_LEVELS);

  tlca_pkg::dp_cmd_t  cmd;
  tlca_pkg::dp_stat_t stat;
  logic [LW-1:0]      level;

  tlca_ctrl #(.LIFT_LEVELS(LIFT_LEVELS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .level     (level)
  );

  tlca_dp #(.MAX_NODES(MAX_NODES), .LIFT_LEVELS(LIFT_LEVELS)) u_dp (
    .clk               (clk),
    .in_node_a         (in_node_a),
    .in_node_b         (in_node_b),
    .cmd               (cmd),
    .level             (level),
    .stat              (stat),
    .out_ancestor_node (out_ancestor_node)
  );

endmodule

>>> rtl/tlca_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlca_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/tlca_ctrl.sv
// Sequencer of the tree LCA block: attach and query schedules, result slot.
module tlca_ctrl #(
  parameter int  LIFT_LEVELS = tlca_pkg::LIFT_LEVELS_DEF,
  localparam int LW          = $clog2(LIFT_LEVELS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  tlca_pkg::dp_stat_t stat,
  output tlca_pkg::dp_cmd_t  cmd,
  output logic [LW-1:0]      level
);

  localparam logic [LW-1:0] LAST = LW'(LIFT_LEVELS - 1);

  tlca_pkg::state_t state_r, state_nxt;
  logic [LW-1:0]    k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlca_pkg::ST_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    cmd.op       = tlca_pkg::DP_HOLD;
    cmd.depth_we = 1'b0;
    cmd.res_load = 1'b0;
    cmd.res_sel  = tlca_pkg::RES_ZERO;
    cmd.out_load = 1'b0;
    case (state_r)
      tlca_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = tlca_pkg::DP_LOAD;
          state_nxt = (in_op == tlca_pkg::OP_QUERY) ? tlca_pkg::ST_Q_START
                                                     : tlca_pkg::ST_ATT_START;
        end
      end
      tlca_pkg::ST_ATT_START: begin
        if (stat.attach_ok) begin
          cmd.op    = tlca_pkg::DP_ATT_START;
          k_nxt     = LW'(1);
          state_nxt = tlca_pkg::ST_ATT_LVL;
        end else begin
          state_nxt = tlca_pkg::ST_IDLE;
        end
      end
      tlca_pkg::ST_ATT_LVL: begin
        cmd.op = tlca_pkg::DP_ATT_LVL;
        // The parent's depth returns in the first level cycle.
        cmd.depth_we = (k_r == LW'(1));
        if (k_r == LAST) begin
          state_nxt = tlca_pkg::ST_IDLE;
        end else begin
          k_nxt = k_r + LW'(1);
        end
      end
      tlca_pkg::ST_Q_START: begin
        if (!stat.range_ok) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = tlca_pkg::RES_ZERO;
          state_nxt    = tlca_pkg::ST_RESULT;
        end else if (stat.same) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = tlca_pkg::RES_U;
          state_nxt    = tlca_pkg::ST_RESULT;
        end else begin
          cmd.op    = tlca_pkg::DP_Q_START;
          state_nxt = tlca_pkg::ST_Q_DEPTH_U;
        end
      end
      tlca_pkg::ST_Q_DEPTH_U: begin
        cmd.op    = tlca_pkg::DP_Q_DEPTH_U;
        state_nxt = tlca_pkg::ST_Q_DEPTH_V;
      end
      tlca_pkg::ST_Q_DEPTH_V: begin
        cmd.op    = tlca_pkg::DP_Q_DEPTH_V;
        k_nxt     = LAST;
        state_nxt = tlca_pkg::ST_Q_LIFT;
      end
      tlca_pkg::ST_Q_LIFT: begin
        cmd.op = tlca_pkg::DP_Q_LIFT;
        if (k_r != '0) begin
          k_nxt = k_r - LW'(1);
        end else if (stat.lift_meet) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = tlca_pkg::RES_LIFT;
          state_nxt    = tlca_pkg::ST_RESULT;
        end else begin
          k_nxt     = LAST;
          state_nxt = tlca_pkg::ST_Q_PAIR;
        end
      end
      tlca_pkg::ST_Q_PAIR: begin
        cmd.op = tlca_pkg::DP_Q_PAIR;
        if (k_r != '0) begin
          k_nxt = k_r - LW'(1);
        end else begin
          state_nxt = tlca_pkg::ST_Q_FINAL;
        end
      end
      tlca_pkg::ST_Q_FINAL: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = tlca_pkg::RES_ANC;
        state_nxt    = tlca_pkg::ST_RESULT;
      end
      tlca_pkg::ST_RESULT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = tlca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tlca_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = (out_valid_r && out_stall) || cmd.out_load;
  end

  assign in_stall  = (state_r != tlca_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign level     = k_r;

endmodule

>>> rtl/tlca_dp.sv
// Datapath of the tree LCA block: depth and ancestor memories, node registers.
module tlca_dp #(
  parameter int  MAX_NODES   = tlca_pkg::MAX_NODES_DEF,
  parameter int  LIFT_LEVELS = tlca_pkg::LIFT_LEVELS_DEF,
  localparam int LW          = $clog2(LIFT_LEVELS)
) (
  input  logic                        clk,
  input  logic [tlca_pkg::NODE_W-1:0] in_node_a,
  input  logic [tlca_pkg::NODE_W-1:0] in_node_b,
  input  tlca_pkg::dp_cmd_t           cmd,
  input  logic [LW-1:0]               level,
  output tlca_pkg::dp_stat_t          stat,
  output logic [tlca_pkg::NODE_W-1:0] out_ancestor_node
);

  localparam int NW     = tlca_pkg::NODE_W;
  localparam int IW     = $clog2(MAX_NODES);
  localparam int AW     = $clog2(MAX_NODES * LIFT_LEVELS);
  localparam int DIFF_W = (IW > LIFT_LEVELS) ? IW : LIFT_LEVELS;
  localparam logic [LW-1:0] LAST = LW'(LIFT_LEVELS - 1);

  function automatic logic [AW-1:0] anc_addr(input logic [NW-1:0] node,
                                             input logic [LW-1:0] lvl);
    anc_addr = AW'(node) * AW'(LIFT_LEVELS) + AW'(lvl);
  endfunction

  function automatic logic in_rng(input logic [NW-1:0] node);
    in_rng = (32'(node) < 32'(MAX_NODES));
  endfunction

  logic [NW-1:0]          u_r, u_nxt, v_r, v_nxt;
  logic [IW-1:0]          du_r, du_nxt;
  logic [LIFT_LEVELS-1:0] diff_r, diff_nxt;
  logic [NW-1:0]          res_r, res_nxt, out_r, out_nxt;
  logic                   a_hit_r, a_zero_r, b_zero_r, d_zero_r;
  logic [NW-1:0]          hit_data_r;

  logic                   d_we;
  logic [IW-1:0]          d_waddr, d_raddr, d_q, d_wdata, dq;
  logic                   a_we;
  logic [AW-1:0]          a_waddr, a_raddr, b_raddr;
  logic [NW-1:0]          a_wdata, a_q, b_q, qa, qb;
  logic [NW-1:0]          a_rnode, b_rnode;
  logic [LW-1:0]          a_rlvl, b_rlvl, a_wlvl;

  logic                   swap, differ;
  logic [NW-1:0]          u_sw, v_sw, u_lift, u_pair, v_pair;
  logic [IW-1:0]          dd;
  logic [DIFF_W-1:0]      dd_ext;
  logic [LW-1:0]          level_m1;

  tlca_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_depth_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_q)
  );

  // Two copies of the ancestor table give two reads per cycle.
  tlca_ram #(.WIDTH(NW), .DEPTH(MAX_NODES * LIFT_LEVELS)) u_anc_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_q)
  );

  tlca_ram #(.WIDTH(NW), .DEPTH(MAX_NODES * LIFT_LEVELS)) u_anc_ram_b (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (b_raddr),
    .rdata (b_q)
  );

  // Node 0 is never written, so its entries read as zero by a flag.
  // A read from copy a of the entry written in the same cycle returns the new value.
  assign dq = d_zero_r ? '0 : d_q;
  assign qa = a_hit_r ? hit_data_r : (a_zero_r ? '0 : a_q);
  assign qb = b_zero_r ? '0 : b_q;

  assign level_m1 = level - LW'(1);
  assign swap     = (du_r < dq);
  assign u_sw     = swap ? v_r : u_r;
  assign v_sw     = swap ? u_r : v_r;
  assign dd       = swap ? (dq - du_r) : (du_r - dq);
  assign dd_ext   = DIFF_W'(dd);
  assign u_lift   = diff_r[level] ? qa : u_r;
  assign differ   = (qa != qb);
  assign u_pair   = differ ? qa : u_r;
  assign v_pair   = differ ? qb : v_r;

  assign d_we    = cmd.depth_we;
  assign d_waddr = IW'(u_r);
  assign d_wdata = (dq >= IW'(MAX_NODES - 1)) ? IW'(MAX_NODES - 1) : dq + IW'(1);

  assign a_waddr = anc_addr(u_r, a_wlvl);
  assign a_raddr = anc_addr(a_rnode, a_rlvl);
  assign b_raddr = anc_addr(b_rnode, b_rlvl);

  always_comb begin
    u_nxt    = u_r;
    v_nxt    = v_r;
    du_nxt   = du_r;
    diff_nxt = diff_r;
    d_raddr  = IW'(v_r);
    a_we     = 1'b0;
    a_wlvl   = level;
    a_wdata  = qa;
    a_rnode  = u_r;
    a_rlvl   = level;
    b_rnode  = v_r;
    b_rlvl   = level;
    case (cmd.op)
      tlca_pkg::DP_LOAD: begin
        u_nxt = in_node_a;
        v_nxt = in_node_b;
      end
      tlca_pkg::DP_ATT_START: begin
        a_we    = 1'b1;
        a_wlvl  = '0;
        a_wdata = v_r;
        a_rnode = v_r;
        a_rlvl  = '0;
      end
      tlca_pkg::DP_ATT_LVL: begin
        // qa is this level's ancestor; its own entry at this level is the next.
        a_we    = 1'b1;
        a_wdata = qa;
        a_rnode = qa;
      end
      tlca_pkg::DP_Q_START: begin
        d_raddr = IW'(u_r);
      end
      tlca_pkg::DP_Q_DEPTH_U: begin
        du_nxt = dq;
      end
      tlca_pkg::DP_Q_DEPTH_V: begin
        u_nxt    = u_sw;
        v_nxt    = v_sw;
        diff_nxt = dd_ext[LIFT_LEVELS-1:0];
        a_rnode  = u_sw;
        a_rlvl   = LAST;
      end
      tlca_pkg::DP_Q_LIFT: begin
        u_nxt   = u_lift;
        a_rnode = u_lift;
        if (level != '0) begin
          a_rlvl = level_m1;
        end else begin
          a_rlvl = LAST;
          b_rlvl = LAST;
        end
      end
      tlca_pkg::DP_Q_PAIR: begin
        u_nxt   = u_pair;
        v_nxt   = v_pair;
        a_rnode = u_pair;
        b_rnode = v_pair;
        a_rlvl  = (level != '0) ? level_m1 : '0;
        b_rlvl  = (level != '0) ? level_m1 : '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_nxt = res_r;
    if (cmd.res_load) begin
      case (cmd.res_sel)
        tlca_pkg::RES_ZERO: res_nxt = '0;
        tlca_pkg::RES_U:    res_nxt = u_r;
        tlca_pkg::RES_LIFT: res_nxt = u_lift;
        tlca_pkg::RES_ANC:  res_nxt = qa;
        default:            res_nxt = '0;
      endcase
    end
    out_nxt = cmd.out_load ? res_r : out_r;
  end

  always_ff @(posedge clk) begin
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    du_r       <= du_nxt;
    diff_r     <= diff_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
    d_zero_r   <= (d_raddr == '0);
    a_zero_r   <= (a_rnode == '0);
    b_zero_r   <= (b_rnode == '0);
    a_hit_r    <= a_we && (a_raddr == a_waddr);
    hit_data_r <= a_wdata;
  end

  assign stat.attach_ok = (u_r != '0) && in_rng(u_r) && in_rng(v_r);
  assign stat.range_ok  = in_rng(u_r) && in_rng(v_r);
  assign stat.same      = (u_r == v_r);
  assign stat.lift_meet = (u_lift == v_r);

  assign out_ancestor_node = out_r;

endmodule

>>> rtl/tlca_checker.sv
// Port-level assertions for the tree LCA block and their bind.
module tlca_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        in_op,
  input logic [tlca_pkg::NODE_W-1:0] in_node_a,
  input logic [tlca_pkg::NODE_W-1:0] in_node_b,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [tlca_pkg::NODE_W-1:0] out_ancestor_node
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ancestor_node))
    else $error("result changed or dropped while stalled");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while an item is in work");

  // A result only appears at the end of a query, never from the idle state.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  // A query of one of nodes 0 to 3 with itself answers that node.
  a_same_node: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == tlca_pkg::OP_QUERY) &&
    (in_node_a == in_node_b) && (in_node_a[tlca_pkg::NODE_W-1:2] == '0) &&
    !out_valid
    |=> ##2 out_valid && (out_ancestor_node == $past(in_node_a, 3)))
    else $error("query of a node with itself gave a wrong result");

endmodule

bind tree_lca_binary_lifting tlca_checker u_tlca_checker (.*);

>>> bench/tree_lca_binary_lifting_tb.sv
// Self-checking testbench for the binary-lifting lowest-common-ancestor block.
module tree_lca_binary_lifting_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 12;
  localparam int NODES      = tlca_pkg::MAX_NODES_DEF;
  localparam int LEVELS     = tlca_pkg::LIFT_LEVELS_DEF;
  localparam int LONG_HOLD  = 300;

  typedef logic [tlca_pkg::NODE_W-1:0] node_t;

  typedef struct packed {
    tlca_pkg::op_t op;
    node_t         a;
    node_t         b;
    logic          known;
    node_t         lca;
  } dir_row_t;

  // Small tree: 1 at the top, 2 and 3 under it, 4 under 2, 1023 under 4,
  // 512 under 3, then 682 under 1023 and 341 under 512, then 512 moved under 4.
  localparam dir_row_t DIRECTED [24] = '{
    '{tlca_pkg::OP_QUERY,  10'd0,    10'd0,    1'b1, 10'd0},
    '{tlca_pkg::OP_ATTACH, 10'd0,    10'd0,    1'b0, 10'd0},
    '{tlca_pkg::OP_ATTACH, 10'd1,    10'd0,    1'b0, 10'd0},
    '{tlca_pkg::OP_ATTACH, 10'd2,    10'd1,    1'b0, 10'd0},
    '{tlca_pkg::OP_ATTACH, 10'd3,    10'd1,    1'b0, 10'd0},
    '{tlca_pkg::OP_ATTACH, 10'd4,    10'd2,    1'b0, 10'd0},
    '{tlca_pkg::OP_ATTACH, 10'd1023, 10'd4,    1'b0, 10'd0},
    '{tlca_pkg::OP_ATTACH, 10'd512,  10'd3,    1'b0, 10'd0},
    '{tlca_pkg::OP_QUERY,  10'd1023, 10'd1023, 1'b1, 10'd1023},
    '{tlca_pkg::OP_QUERY,  10'd1023, 10'd0,    1'b1, 10'd0},
    '{tlca_pkg::OP_QUERY,  10'd0,    10'd512,  1'b1, 10'd0},
    '{tlca_pkg::OP_QUERY,  10'd4,    10'd1023, 1'b1, 10'd4},
    '{tlca_pkg::OP_QUERY,  10'd1023, 10'd4,    1'b1, 10'd4},
    '{tlca_pkg::OP_QUERY,  10'd1023, 10'd512,  1'b1, 10'd1},
    '{tlca_pkg::OP_QUERY,  10'd4,    10'd3,    1'b0, 10'd0},
    '{tlca_pkg::OP_ATTACH, 10'd0,    10'd1023, 1'b0, 10'd0},
    '{tlca_pkg::OP_ATTACH, 10'd682,  10'd1023, 1'b0, 10'd0},
    '{tlca_pkg::OP_ATTACH, 10'd341,  10'd512,  1'b0, 10'd0},
    '{tlca_pkg::OP_QUERY,  10'd682,  10'd341,  1'b1, 10'd1},
    '{tlca_pkg::OP_QUERY,  10'd341,  10'd682,  1'b1, 10'd1},
    '{tlca_pkg::OP_ATTACH, 10'd512,  10'd4,    1'b0, 10'd0},
    '{tlca_pkg::OP_QUERY,  10'd512,  10'd1023, 1'b1, 10'd4},
    '{tlca_pkg::OP_QUERY,  10'd341,  10'd4,    1'b0, 10'd0},
    '{tlca_pkg::OP_QUERY,  10'd682,  10'd2,    1'b1, 10'd2}
  };

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_stall;
  logic  in_op     = tlca_pkg::OP_ATTACH;
  node_t in_node_a = '0;
  node_t in_node_b = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  node_t out_ancestor_node;

  // Own copy of the tree: depth per node and the 2^k-th ancestor per level.
  node_t tree_depth [NODES];
  node_t jump_tab   [NODES][LEVELS];
  bit    is_live    [NODES];
  node_t live_nodes [$];
  node_t lca_expect_q [$];

  int   mismatch_count = 0;
  int   send_idle_pct  = 0;
  int   stall_pct      = 0;
  logic hold_req       = 1'b0;
  logic hold_taken     = 1'b0;
  int   hold_left      = 0;

  tree_lca_binary_lifting i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_node_a         (in_node_a),
    .in_node_b         (in_node_b),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ancestor_node (out_ancestor_node)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void tree_attach(node_t node, node_t par);
    node_t d;
    if (node == '0) return;
    d = tree_depth[par];
    tree_depth[node] = (d == node_t'(NODES - 1)) ? d : d + 1'b1;
    jump_tab[node][0] = par;
    for (int k = 1; k < LEVELS; k++) begin
      jump_tab[node][k] = jump_tab[jump_tab[node][k-1]][k-1];
    end
  endfunction

  function automatic node_t lca_of(node_t u, node_t v);
    node_t x, y, t, gap;
    if (u == v) return u;
    x = u;
    y = v;
    if (tree_depth[x] < tree_depth[y]) begin
      t = x;
      x = y;
      y = t;
    end
    gap = tree_depth[x] - tree_depth[y];
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (gap[k]) x = jump_tab[x][k];
    end
    if (x == y) return x;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (jump_tab[x][k] != jump_tab[y][k]) begin
        x = jump_tab[x][k];
        y = jump_tab[y][k];
      end
    end
    return jump_tab[x][0];
  endfunction

  function automatic node_t pick_live();
    return live_nodes[$urandom_range(live_nodes.size() - 1)];
  endfunction

  // Offers one item, waits for it to be taken and updates the predictor.
  // Valid stays high afterwards so back-to-back items need no gap.
  task automatic send_item(tlca_pkg::op_t op, node_t a, node_t b,
                           logic known = 1'b0, node_t lca = '0);
    node_t expect_lca;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= op;
    in_node_a <= a;
    in_node_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == tlca_pkg::OP_ATTACH) begin
      tree_attach(a, b);
      if (!is_live[a]) begin
        is_live[a] = 1'b1;
        live_nodes = {live_nodes, a};
      end
    end else begin
      expect_lca   = known ? lca : lca_of(a, b);
      lca_expect_q = {lca_expect_q, expect_lca};
    end
  endtask

  // Mostly attaches of fresh nodes under live parents and queries of live
  // pairs; a few re-attaches and ignored attaches of the sentinel.
  task automatic send_random_item();
    int    r;
    node_t a;
    r = $urandom_range(99);
    if (r < 5) begin
      send_item(tlca_pkg::OP_ATTACH, '0, pick_live());
    end else if (r < 45) begin
      if (live_nodes.size() < NODES && $urandom_range(99) < 80) begin
        do a = node_t'($urandom_range(NODES - 1, 1)); while (is_live[a]);
      end else begin
        a = node_t'($urandom_range(NODES - 1, 1));
      end
      send_item(tlca_pkg::OP_ATTACH, a, pick_live());
    end else begin
      send_item(tlca_pkg::OP_QUERY, pick_live(), pick_live());
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (lca_expect_q.size() == 0) begin
          $display("%0t: unexpected ancestor item, expected none, got %0d",
                   $time, out_ancestor_node);
          mismatch_count++;
        end else begin
          if (out_ancestor_node !== lca_expect_q[0]) begin
            $display("%0t: ancestor mismatch, expected %0d, got %0d",
                     $time, lca_expect_q[0], out_ancestor_node);
            mismatch_count++;
          end
          void'(lca_expect_q.pop_front());
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= LONG_HOLD;
        out_stall  <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int idle_mode [4];
    int stall_mode [4];
    idle_mode  = '{0, 68, 0, 33};
    stall_mode = '{0, 0, 68, 33};
    for (int n = 0; n < NODES; n++) begin
      tree_depth[n] = '0;
      for (int k = 0; k < LEVELS; k++) jump_tab[n][k] = '0;
      is_live[n] = 1'b0;
    end
    is_live[0] = 1'b1;
    live_nodes = {live_nodes, node_t'(0)};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      send_item(DIRECTED[i].op, DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].known,
                DIRECTED[i].lca);
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_mode[p];
      stall_pct    <= stall_mode[p];
      repeat (140) send_random_item();
    end

    // One long chain so that lifts use every level and depths saturate.
    send_idle_pct = 0;
    stall_pct    <= 33;
    for (int n = 1; n < NODES; n++) begin
      send_item(tlca_pkg::OP_ATTACH, node_t'(n), node_t'(n - 1));
      if (n % 16 == 0) send_item(tlca_pkg::OP_QUERY, pick_live(), pick_live());
    end
    repeat (40) send_item(tlca_pkg::OP_QUERY, pick_live(), pick_live());
    send_item(tlca_pkg::OP_ATTACH, 10'd700, 10'd1023);
    send_item(tlca_pkg::OP_QUERY, 10'd700, 10'd1023);
    send_item(tlca_pkg::OP_QUERY, 10'd700, 10'd1);
    send_item(tlca_pkg::OP_ATTACH, 10'd1023, 10'd1023);
    send_item(tlca_pkg::OP_QUERY, 10'd1023, 10'd511);
    send_item(tlca_pkg::OP_QUERY, 10'd3, 10'd1023);

    // Receiver holds off for a long stretch while queries keep coming.
    stall_pct <= 0;
    hold_req  <= 1'b1;
    repeat (12) send_item(tlca_pkg::OP_QUERY, pick_live(), pick_live());

    send_idle_pct = 33;
    stall_pct    <= 33;
    repeat (60) send_random_item();

    in_valid  <= 1'b0;
    stall_pct <= 0;
    while (lca_expect_q.size() != 0) @(posedge clk);
    repeat (2 * LEVELS + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
